FILE: hdl/lpf_pkg.sv
// ----------------------------------------------------------------------------
// lpf_pkg: shared types and constants for the last prime finder
// Holds the default value width, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lpf_pkg;

  localparam int VALUE_BITS_DEF = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCREEN,
    ST_DIV,
    ST_NEXT,
    ST_COMMIT
  } lpf_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word, d = 3, d*d = 9
    logic start_div;  // clear remainder, start serial divide
    logic div_step;   // one restoring-divide bit
    logic advance;    // d += 2, d*d updated
    logic commit;     // close out the current word
    logic is_prime;   // verdict that goes with commit
  } lpf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic below_two;
    logic is_two;
    logic is_even;
    logic sq_over;    // d*d > value
    logic div_done;   // current step is the last divide bit
    logic rem_zero;
    logic is_last;
    logic out_free;   // output register empty or draining this cycle
  } lpf_sts_t;

endpackage

FILE: hdl/lpf_ctrl.sv
// ----------------------------------------------------------------------------
// lpf_ctrl: sequencer for the trial-division test
// Screens each word, walks odd divisors through the serial divider and
// commits the verdict.
// ----------------------------------------------------------------------------
module lpf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lpf_pkg::lpf_sts_t sts,
  output lpf_pkg::lpf_cmd_t cmd
);

  lpf_pkg::lpf_state_t state_r, state_nxt;
  logic                prime_r, prime_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpf_pkg::ST_IDLE;
      prime_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prime_r <= prime_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    prime_nxt = prime_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      lpf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = lpf_pkg::ST_SCREEN;
        end
      end
      lpf_pkg::ST_SCREEN: begin
        if (sts.below_two || (sts.is_even && !sts.is_two)) begin
          prime_nxt = 1'b0;
          state_nxt = lpf_pkg::ST_COMMIT;
        end else if (sts.is_two || sts.sq_over) begin
          prime_nxt = 1'b1;
          state_nxt = lpf_pkg::ST_COMMIT;
        end else begin
          cmd.start_div = 1'b1;
          state_nxt     = lpf_pkg::ST_DIV;
        end
      end
      lpf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = lpf_pkg::ST_NEXT;
        end
      end
      lpf_pkg::ST_NEXT: begin
        if (sts.rem_zero) begin
          prime_nxt = 1'b0;
          state_nxt = lpf_pkg::ST_COMMIT;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = lpf_pkg::ST_SCREEN;
        end
      end
      lpf_pkg::ST_COMMIT: begin
        // a final word waits for room in the output register
        if (!sts.is_last || sts.out_free) begin
          cmd.commit   = 1'b1;
          cmd.is_prime = prime_r;
          state_nxt    = lpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lpf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/lpf_dp.sv
// ----------------------------------------------------------------------------
// lpf_dp: datapath for the last prime finder
// Word register, odd divisor and its square, bit-serial restoring remainder,
// kept prime and the output register.
// ----------------------------------------------------------------------------
module lpf_dp #(
  parameter int VALUE_BITS = lpf_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  in_is_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_found,
  output logic [VALUE_BITS-1:0] out_last_prime,
  input  lpf_pkg::lpf_cmd_t     cmd,
  output lpf_pkg::lpf_sts_t     sts
);

  localparam int SQ_BITS  = VALUE_BITS + 3;
  localparam int CNT_BITS = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] value_r, div_r, rem_r, shift_r, kept_r, oprime_r;
  logic [SQ_BITS-1:0]    sq_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  last_r, have_r, ovalid_r, ofound_r;
  logic [VALUE_BITS:0]   trial;
  logic                  fits;

  assign trial = {rem_r, shift_r[VALUE_BITS-1]};
  assign fits  = trial >= {1'b0, div_r};

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_value;
      last_r  <= in_is_last;
      div_r   <= VALUE_BITS'(3);
      sq_r    <= SQ_BITS'(9);
    end else if (cmd.advance) begin
      div_r <= div_r + VALUE_BITS'(2);
      sq_r  <= sq_r + SQ_BITS'({div_r, 2'b00}) + SQ_BITS'(4);
    end
    if (cmd.start_div) begin
      rem_r   <= '0;
      shift_r <= value_r;
      cnt_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r   <= fits ? VALUE_BITS'(trial - {1'b0, div_r}) : trial[VALUE_BITS-1:0];
      shift_r <= {shift_r[VALUE_BITS-2:0], 1'b0};
      cnt_r   <= cnt_r + CNT_BITS'(1);
    end
    if (cmd.commit && last_r) begin
      ofound_r <= have_r | cmd.is_prime;
      oprime_r <= cmd.is_prime ? value_r : kept_r;
    end
  end

  // kept prime and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r   <= '0;
      have_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.commit && last_r) begin
        kept_r   <= '0;
        have_r   <= 1'b0;
        ovalid_r <= 1'b1;
      end else begin
        if (cmd.commit && cmd.is_prime) begin
          kept_r <= value_r;
          have_r <= 1'b1;
        end
        if (!out_stall) begin
          ovalid_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid      = ovalid_r;
  assign out_found      = ofound_r;
  assign out_last_prime = oprime_r;

  always_comb begin
    sts.below_two = value_r < VALUE_BITS'(2);
    sts.is_two    = value_r == VALUE_BITS'(2);
    sts.is_even   = ~value_r[0];
    sts.sq_over   = sq_r > SQ_BITS'(value_r);
    sts.div_done  = cnt_r == CNT_BITS'(VALUE_BITS - 1);
    sts.rem_zero  = rem_r == '0;
    sts.is_last   = last_r;
    sts.out_free  = !ovalid_r || !out_stall;
  end

endmodule

FILE: hdl/last_prime_finder.sv
// ----------------------------------------------------------------------------
// last_prime_finder: latest prime of a word sequence, by trial division
// Tests each input word for primality and reports the latest prime of the
// sequence when the word flagged as last has been examined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries in_value and in_is_last. A word
//   is taken when in_valid is high and in_stall low. One word is worked on
//   at a time; in_stall stays high until its verdict is committed.
//   Output channel out_valid/out_stall carries out_found and out_last_prime,
//   one result word per sequence, after the word with in_is_last set.
//   out_last_prime is 0 when no prime was seen.
// Steps (VALUE_BITS = N):
//   Words below 2, even words and 2 itself: load, screen and commit.
//   Otherwise each odd divisor d with d*d <= value takes the screen step,
//   N steps of the bit-serial remainder unit and the remainder check; a
//   16-bit prime near 65521 takes about 127 divisors. The serial remainder
//   loop sets the rate.
// Stall: the result sits in an output register; new words are still taken
//   while it waits. A final word whose result finds that register full
//   holds at commit until the receiver drains it.
// Reset (rst_n low, synchronous): clears the sequencer, the kept prime and
//   the output valid.
// ----------------------------------------------------------------------------
module last_prime_finder #(
  parameter int VALUE_BITS = lpf_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  in_is_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_found,
  output logic [VALUE_BITS-1:0] out_last_prime
);

  lpf_pkg::lpf_cmd_t cmd;
  lpf_pkg::lpf_sts_t sts;

  // sequencer: screen, divide, advance divisor, commit
  lpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // word, divisor, remainder unit, kept prime, output register
  lpf_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_last_prime (out_last_prime),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

FILE: hdl/lpf_checker.sv
// ----------------------------------------------------------------------------
// lpf_checker: port-level checks for the last prime finder
// Watches the top-level ports over time; bound to last_prime_finder.
// ----------------------------------------------------------------------------
module lpf_checker #(
  parameter int VALUE_BITS = lpf_pkg::VALUE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [VALUE_BITS-1:0] in_value,
  input logic                  in_is_last,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_found,
  input logic [VALUE_BITS-1:0] out_last_prime
);

  // a taken word keeps the block busy for at least the screen cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("in_stall low right after a word was taken");

  // stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_value)
      && $stable(in_is_last))
    else $error("stalled input word changed");

  // no prime found reports zero
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last_prime == '0)
    else $error("out_last_prime nonzero without found");

  // a reported prime is at least 2
  a_prime_ge_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_last_prime >= VALUE_BITS'(2))
    else $error("reported prime below 2");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found)
      && $stable(out_last_prime))
    else $error("stalled result word changed");

endmodule

bind last_prime_finder lpf_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_lpf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_value       (in_value),
  .in_is_last     (in_is_last),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_found      (out_found),
  .out_last_prime (out_last_prime)
);

FILE: verif/tb_last_prime_finder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_last_prime_finder: self-checking bench for the last prime finder
// Sends sequences of 16-bit words, each closed by a word with is_last set.
// A trial-division model of its own tracks the latest prime and predicts one
// report per sequence. Random gaps on the input side and random stalls on
// the result side, with some stretches of neither.
// ----------------------------------------------------------------------------
module tb_last_prime_finder;

  localparam int W = lpf_pkg::VALUE_BITS_DEF;
  // Worst word is a prime near 2^16: ~127 divisors, each through the serial
  // remainder loop, plus the longest result stall. Several times that margin.
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int TAIL_CYCLES     = 2600;
  localparam int RANDOM_WORDS    = 270;
  localparam int MAX_SHOWN       = 10;

  typedef struct {
    logic [W-1:0] value;
    logic         is_last;
    bit           drain_first;  // hold off until every report is back
  } seq_word_t;

  typedef struct {
    logic         found;
    logic [W-1:0] prime;
  } prime_report_t;

  logic         clk            = 1'b0;
  logic         rst_n          = 1'b0;
  logic         in_valid       = 1'b0;
  logic         in_stall;
  logic [W-1:0] in_value       = '0;
  logic         in_is_last     = 1'b0;
  logic         out_valid;
  logic         out_stall      = 1'b0;
  logic         out_found;
  logic [W-1:0] out_last_prime;

  seq_word_t     word_queue[$];      // words waiting to be sent
  prime_report_t report_queue[$];    // predicted reports, oldest first

  // model state: latest prime of the open sequence
  logic [W-1:0] kept_prime = '0;
  logic         have_prime = 1'b0;

  int reports_due  = 0;   // bumped by the driver when a last word goes in
  int reports_seen = 0;   // bumped (nonblocking) by the monitor
  int error_count  = 0;
  int idle_cycles  = 0;
  int send_gap     = 0;
  int send_calm    = 0;
  int hold_left    = 0;
  int hold_calm    = 0;

  last_prime_finder #(.VALUE_BITS(W)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_last_prime (out_last_prime)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------
  function automatic bit prime_by_division(logic [W-1:0] v);
    int unsigned n;
    int unsigned d;
    n = 32'(v);
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    for (d = 3; d * d <= n; d += 2)
      if (n % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  // first prime at or above v; the top 16-bit prime if none is left
  function automatic logic [W-1:0] prime_from(int unsigned v);
    int unsigned x;
    for (x = v; x < (1 << W); x++)
      if (prime_by_division(x[W-1:0])) return x[W-1:0];
    return W'(65521);
  endfunction

  // one accepted word: update the kept prime, predict a report on the last
  task automatic track_word(logic [W-1:0] v, logic last);
    prime_report_t r;
    if (prime_by_division(v)) begin
      kept_prime = v;
      have_prime = 1'b1;
    end
    if (last) begin
      r.found = have_prime;
      r.prime = have_prime ? kept_prime : '0;
      report_queue.push_back(r);
      reports_due++;
      kept_prime = '0;
      have_prime = 1'b0;
    end
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 150);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_word(int unsigned v, bit last, bit drain = 1'b0);
    seq_word_t w;
    w.value       = v[W-1:0];
    w.is_last     = last;
    w.drain_first = drain;
    word_queue.push_back(w);
  endtask

  // mix of small values, primes of both sizes, odd prime squares and noise
  function automatic int unsigned random_value();
    int unsigned r;
    int unsigned p;
    r = $urandom_range(0, 99);
    if (r < 18) return $urandom_range(0, 40);
    if (r < 40) return 32'(prime_from($urandom_range(0, 4095)));
    if (r < 58) return 32'(prime_from($urandom_range(0, (1 << W) - 1)));
    if (r < 70) begin
      p = 32'(prime_from($urandom_range(3, 250)));  // p*p stays within 16 bits
      return p * p;
    end
    return $urandom_range(0, (1 << W) - 1);
  endfunction

  task automatic add_random_sequence(bit drain);
    int unsigned r;
    int          len;
    int          i;
    r = $urandom_range(0, 99);
    if (r < 50)      len = $urandom_range(1, 3);
    else if (r < 90) len = $urandom_range(4, 8);
    else             len = $urandom_range(9, 16);
    for (i = 0; i < len; i++)
      add_word(random_value(), i == len - 1, drain && i == 0);
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued words; payload held while stalled
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_words
    seq_word_t w;
    bit        took;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_value   <= '0;
      in_is_last <= 1'b0;
      send_gap   = 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) track_word(in_value, in_is_last);
      if (!in_valid || took) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (word_queue.size() != 0 &&
                     !(word_queue[0].drain_first && reports_seen != reports_due)) begin
          w = word_queue.pop_front();
          in_valid   <= 1'b1;
          in_value   <= w.value;
          in_is_last <= w.is_last;
          if (send_calm != 0) begin
            send_calm--;
            send_gap = 0;
          end else begin
            send_gap = pick_gap();
            if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 60);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each report against the oldest prediction, drives stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_reports
    prime_report_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        reports_seen <= reports_seen + 1;
        if (report_queue.size() == 0) begin
          error_count++;
          if (error_count <= MAX_SHOWN)
            $display("%0t: report with none pending: found=%0b prime=%0d",
                     $realtime, out_found, out_last_prime);
        end else begin
          want = report_queue.pop_front();
          if (out_found !== want.found || out_last_prime !== want.prime) begin
            error_count++;
            if (error_count <= MAX_SHOWN)
              $display("%0t: report mismatch: want found=%0b prime=%0d, got found=%0b prime=%0d",
                       $realtime, want.found, want.prime, out_found, out_last_prime);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (hold_calm != 0) begin
          hold_calm--;
        end else begin
          if ($urandom_range(0, 5) == 0) hold_left = pick_gap();
          if ($urandom_range(0, 299) == 0) hold_calm = $urandom_range(200, 600);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles with no word moving on either side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("tb_last_prime_finder: errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int sent;

    // one-word sequences: below two, two, a small odd prime, even words,
    // odd prime squares, all-ones and the top 16-bit prime (slowest path)
    add_word(0, 1'b1);
    add_word(1, 1'b1);
    add_word(2, 1'b1);
    add_word(3, 1'b1);
    add_word(4, 1'b1);
    add_word(9, 1'b1);
    add_word(25, 1'b1);
    add_word(63001, 1'b1);   // 251 squared, runs the divisor loop to the end
    add_word(65535, 1'b1);
    add_word(65521, 1'b1);
    add_word(65534, 1'b1);
    add_word(32768, 1'b1);
    // latest prime wins, last word itself not prime
    add_word(7, 1'b0);
    add_word(8, 1'b0);
    add_word(13, 1'b0);
    add_word(15, 1'b1);
    // right after a found sequence: kept prime must be cleared
    add_word(0, 1'b0);
    add_word(1, 1'b0);
    add_word(4, 1'b0);
    add_word(6, 1'b1);
    // last word is the prime, first word is a big prime
    add_word(65521, 1'b0);
    add_word(2, 1'b1);
    // first word prime, the rest not
    add_word(65519, 1'b0);
    add_word(65535, 1'b1);

    // random sequences; some start only after everything has drained
    sent = word_queue.size();
    add_random_sequence(1'b1);
    while (word_queue.size() < sent + RANDOM_WORDS)
      add_random_sequence($urandom_range(0, 11) == 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (word_queue.size() != 0 || in_valid) @(posedge clk);
    while (reports_seen != reports_due) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && report_queue.size() == 0) begin
      $display("tb_last_prime_finder: clean");
    end else begin
      $display("tb_last_prime_finder: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/lpf_pkg.sv
hdl/lpf_ctrl.sv
hdl/lpf_dp.sv
hdl/last_prime_finder.sv
hdl/lpf_checker.sv
verif/tb_last_prime_finder.sv
